### design/lbps_pkg.sv
// Package: shared constants, codes and word types of the LED blink pattern sequencer.
`timescale 1ns / 1ps

package lbps_pkg;

  // Counter widths
  localparam int TIME_BITS  = 16;
  localparam int COUNT_BITS = 8;
  localparam int ELAP_BITS  = TIME_BITS + 1;
  localparam int TONE_BITS  = 15;
  localparam int MODE_BITS  = 3;
  localparam int STATE_BITS = 3;

  // Highest tone accepted, in Hz
  localparam logic [TONE_BITS-1:0] TONE_MAX = TONE_BITS'(20000);

  // Reset defaults of the stored burst and cycle settings
  localparam logic [TIME_BITS-1:0]  RST_ON_TIME  = TIME_BITS'(200);
  localparam logic [TIME_BITS-1:0]  RST_OFF_TIME = TIME_BITS'(1000);
  localparam logic [TIME_BITS-1:0]  RST_PERIOD   = TIME_BITS'(5000);
  localparam logic [COUNT_BITS-1:0] RST_PULSES   = COUNT_BITS'(1);
  localparam logic [TONE_BITS-1:0]  RST_TONE     = TONE_BITS'(1000);

  // Configuration register indexes
  localparam logic CFG_INVERT = 1'b0;
  localparam logic CFG_BUZZER = 1'b1;

  // Input word mode codes
  localparam logic [MODE_BITS-1:0] MODE_TICK  = 3'd0;
  localparam logic [MODE_BITS-1:0] MODE_BURST = 3'd1;
  localparam logic [MODE_BITS-1:0] MODE_CYCLE = 3'd2;
  localparam logic [MODE_BITS-1:0] MODE_ON    = 3'd3;
  localparam logic [MODE_BITS-1:0] MODE_OFF   = 3'd4;

  // Run state codes, also reported on the result word
  localparam logic [STATE_BITS-1:0] ST_OFF       = 3'd0;
  localparam logic [STATE_BITS-1:0] ST_ON        = 3'd1;
  localparam logic [STATE_BITS-1:0] ST_CYCLE     = 3'd2;
  localparam logic [STATE_BITS-1:0] ST_PULSE_OFF = 3'd3;
  localparam logic [STATE_BITS-1:0] ST_PULSE_ON  = 3'd4;

  // Logical mode codes (mode to return to after a burst)
  localparam logic [1:0] LOG_OFF   = 2'd0;
  localparam logic [1:0] LOG_ON    = 2'd1;
  localparam logic [1:0] LOG_CYCLE = 2'd2;

  // Input word
  typedef struct packed {
    logic [MODE_BITS-1:0]  mode;
    logic [TIME_BITS-1:0]  on_time;
    logic [TIME_BITS-1:0]  off_time;
    logic [TIME_BITS-1:0]  period;
    logic [COUNT_BITS-1:0] pulse_count;
    logic [TONE_BITS-1:0]  tone_frequency;
  } item_t;

  // Result word
  typedef struct packed {
    logic                  led_level;
    logic [TONE_BITS-1:0]  buzzer_frequency;
    logic [STATE_BITS-1:0] sequencer_state;
  } result_t;

  // Configuration registers
  typedef struct packed {
    logic invert_output;
    logic buzzer_present;
  } cfg_t;

endpackage

### design/lbps_core.sv
// Sequencer state and the single-pass update applied to one input word.
`timescale 1ns / 1ps

module lbps_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  lbps_pkg::item_t  item_i,
  input  lbps_pkg::cfg_t   cfg_i,
  output lbps_pkg::result_t result_o
);
  import lbps_pkg::*;

  logic [STATE_BITS-1:0] run_q, run_d;
  logic [1:0]            logical_q, logical_d;
  logic [TIME_BITS-1:0]  b_on_q, b_on_d, b_off_q, b_off_d;
  logic [COUNT_BITS-1:0] b_total_q, b_total_d, done_q, done_d;
  logic [TONE_BITS-1:0]  tone_q, tone_d;
  logic [TIME_BITS-1:0]  c_on_q, c_on_d, c_off_q, c_off_d, c_per_q, c_per_d;
  logic [COUNT_BITS-1:0] c_pulses_q, c_pulses_d;
  logic [ELAP_BITS-1:0]  pe_q, pe_d, ce_q, ce_d;
  logic                  led_q, led_d;

  logic [ELAP_BITS-1:0]  pe_inc, ce_inc;
  logic [TONE_BITS-1:0]  tone_sat;
  logic                  burst_ok, cycle_ok;

  // Saturating elapsed counts and clamped tone
  assign pe_inc   = (&pe_q) ? pe_q : pe_q + ELAP_BITS'(1);
  assign ce_inc   = (&ce_q) ? ce_q : ce_q + ELAP_BITS'(1);
  assign tone_sat = (item_i.tone_frequency > TONE_MAX) ? TONE_MAX : item_i.tone_frequency;
  assign burst_ok = (item_i.on_time != '0) && (item_i.off_time != '0) &&
                    (item_i.pulse_count != '0);
  assign cycle_ok = burst_ok && (item_i.period != '0);

  // Next state for one word
  always_comb begin
    run_d      = run_q;
    logical_d  = logical_q;
    b_on_d     = b_on_q;
    b_off_d    = b_off_q;
    b_total_d  = b_total_q;
    done_d     = done_q;
    tone_d     = tone_q;
    c_on_d     = c_on_q;
    c_off_d    = c_off_q;
    c_per_d    = c_per_q;
    c_pulses_d = c_pulses_q;
    pe_d       = pe_q;
    ce_d       = ce_q;
    led_d      = led_q;
    unique case (item_i.mode)
      MODE_TICK: begin
        pe_d = pe_inc;
        ce_d = ce_inc;
        if (run_q == ST_CYCLE) begin
          // Retrigger a silent burst from the cycle settings
          if (ce_inc > {1'b0, c_per_q}) begin
            b_on_d    = c_on_q;
            b_off_d   = c_off_q;
            b_total_d = c_pulses_q;
            tone_d    = '0;
            done_d    = '0;
            led_d     = 1'b0;
            run_d     = ST_PULSE_OFF;
            pe_d      = '0;
            ce_d      = '0;
          end
        end else if (run_q == ST_PULSE_OFF) begin
          if (pe_inc > {1'b0, b_off_q}) begin
            if (done_q < b_total_q) begin
              led_d = 1'b1;
              pe_d  = '0;
              run_d = ST_PULSE_ON;
            end else if (logical_q == LOG_ON) begin
              run_d = ST_ON;
              led_d = 1'b1;
            end else if (logical_q == LOG_CYCLE) begin
              run_d = ST_CYCLE;
              led_d = 1'b0;
            end else begin
              run_d = ST_OFF;
              led_d = 1'b0;
            end
          end
        end else if (run_q == ST_PULSE_ON) begin
          if (pe_inc > {1'b0, b_on_q}) begin
            led_d = 1'b0;
            pe_d  = '0;
            run_d = ST_PULSE_OFF;
            if (!(&done_q)) begin
              done_d = done_q + COUNT_BITS'(1);
            end
          end
        end
      end
      MODE_BURST: begin
        if (burst_ok) begin
          b_on_d    = item_i.on_time;
          b_off_d   = item_i.off_time;
          b_total_d = item_i.pulse_count;
          tone_d    = tone_sat;
          done_d    = '0;
          led_d     = 1'b0;
          run_d     = ST_PULSE_OFF;
          pe_d      = '0;
        end
      end
      MODE_CYCLE: begin
        if (cycle_ok) begin
          c_on_d     = item_i.on_time;
          c_off_d    = item_i.off_time;
          c_per_d    = item_i.period;
          c_pulses_d = item_i.pulse_count;
          run_d      = ST_CYCLE;
          logical_d  = LOG_CYCLE;
          ce_d       = '0;
        end
      end
      MODE_ON: begin
        led_d     = 1'b1;
        run_d     = ST_ON;
        logical_d = LOG_ON;
      end
      MODE_OFF: begin
        led_d     = 1'b0;
        run_d     = ST_OFF;
        logical_d = LOG_OFF;
      end
      default: begin
      end
    endcase
  end

  // Result seen after this word
  always_comb begin
    result_o.led_level        = led_d ^ cfg_i.invert_output;
    result_o.buzzer_frequency = (cfg_i.buzzer_present && (run_d == ST_PULSE_ON)) ?
                                tone_d : '0;
    result_o.sequencer_state  = run_d;
  end

  // Commit state on each word taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q      <= ST_OFF;
      logical_q  <= LOG_OFF;
      b_on_q     <= RST_ON_TIME;
      b_off_q    <= RST_OFF_TIME;
      b_total_q  <= RST_PULSES;
      done_q     <= '0;
      tone_q     <= RST_TONE;
      c_on_q     <= RST_ON_TIME;
      c_off_q    <= RST_OFF_TIME;
      c_per_q    <= RST_PERIOD;
      c_pulses_q <= RST_PULSES;
      pe_q       <= '0;
      ce_q       <= '0;
      led_q      <= 1'b0;
    end else if (step_i) begin
      run_q      <= run_d;
      logical_q  <= logical_d;
      b_on_q     <= b_on_d;
      b_off_q    <= b_off_d;
      b_total_q  <= b_total_d;
      done_q     <= done_d;
      tone_q     <= tone_d;
      c_on_q     <= c_on_d;
      c_off_q    <= c_off_d;
      c_per_q    <= c_per_d;
      c_pulses_q <= c_pulses_d;
      pe_q       <= pe_d;
      ce_q       <= ce_d;
      led_q      <= led_d;
    end
  end

endmodule

### design/led_blink_pattern_sequencer_top.sv
// Top level: input register, configuration registers, sequencer core and result register.
`timescale 1ns / 1ps

// LED blink pattern sequencer.
// Input channel (in_valid_i / in_ready_o) takes one word per handshake: a 1 ms
// tick (mode 0) or a command (burst, cycle, steady on, off). Every word gives
// exactly one result word on the output channel (out_valid_o / out_ready_i):
// LED pin level, buzzer tone in Hz (0 silent) and the sequencer state.
// A taken word is registered in the input register; when the result register
// is free or being drained, the core updates the state and loads the result
// register in one step, and out_valid_o rises with it.
// Throughput: one word per cycle unless out_ready_i stalls; the input and result registers
// are one stage each, and the core step is a few compares and counter updates.
// When the receiver stalls, the result register holds and the input register
// keeps one more word; in_ready_o drops only when both are full.
// Configuration (cfg_we_i, cfg_idx_i, cfg_data_i): index 0 inverts the LED
// polarity, index 1 enables the buzzer. Write only while no word is in flight.
// Reset (rst_ni low, asynchronous) empties both registers, sets the sequencer
// off with default burst and cycle settings and clears both config bits.
module led_blink_pattern_sequencer_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [lbps_pkg::MODE_BITS-1:0]      mode_i,
  input  logic [lbps_pkg::TIME_BITS-1:0]      on_time_i,
  input  logic [lbps_pkg::TIME_BITS-1:0]      off_time_i,
  input  logic [lbps_pkg::TIME_BITS-1:0]      period_i,
  input  logic [lbps_pkg::COUNT_BITS-1:0]     pulse_count_i,
  input  logic [lbps_pkg::TONE_BITS-1:0]      tone_frequency_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                led_level_o,
  output logic [lbps_pkg::TONE_BITS-1:0]      buzzer_frequency_o,
  output logic [lbps_pkg::STATE_BITS-1:0]     sequencer_state_o,
  input  logic                                cfg_we_i,
  input  logic                                cfg_idx_i,
  input  logic                                cfg_data_i
);
  import lbps_pkg::*;

  logic    in_v_q;
  item_t   item_q;
  logic    out_v_q;
  result_t out_q;
  result_t core_res;
  cfg_t    cfg_q;
  logic    out_free;
  logic    advance;
  logic    in_take;

  // Handshake: advance when a word is held and the result register is free or being drained
  assign out_free   = !out_v_q || out_ready_i;
  assign advance    = in_v_q && out_free;
  assign in_ready_o = !in_v_q || advance;
  assign in_take    = in_valid_i && in_ready_o;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_BUZZER) begin
        cfg_q.buzzer_present <= cfg_data_i;
      end else begin
        cfg_q.invert_output <= cfg_data_i;
      end
    end
  end

  // Input register: hold the word until the core takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (in_ready_o) begin
      in_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q.mode           <= mode_i;
      item_q.on_time        <= on_time_i;
      item_q.off_time       <= off_time_i;
      item_q.period         <= period_i;
      item_q.pulse_count    <= pulse_count_i;
      item_q.tone_frequency <= tone_frequency_i;
    end
  end

  lbps_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .item_i   (item_q),
    .cfg_i    (cfg_q),
    .result_o (core_res)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (out_free) begin
      out_v_q <= advance;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= core_res;
    end
  end

  assign out_valid_o        = out_v_q;
  assign led_level_o        = out_q.led_level;
  assign buzzer_frequency_o = out_q.buzzer_frequency;
  assign sequencer_state_o  = out_q.sequencer_state;

  // Checks
  a_hold_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_v_q && !out_free) |=> (in_v_q && $stable(item_q)))
    else $error("input word lost while result register blocked");

  a_step_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_v_q)
    else $error("core step produced no result word");

  a_tone_only_on_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && (out_q.buzzer_frequency != '0)) |->
      ((out_q.sequencer_state == ST_PULSE_ON) && cfg_q.buzzer_present))
    else $error("tone driven outside a pulse on phase");

  a_tone_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q |-> (out_q.buzzer_frequency <= TONE_MAX))
    else $error("tone above limit");

endmodule
